@@ hdl/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared widths, codes and reset values of the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

	localparam int KEY_W         = 32;
	localparam int VAL_W         = 32;
	localparam int CAP_W         = 5;
	localparam int ENTRIES_DEF   = 16;

	localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
	localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
	localparam logic [VAL_W-1:0] PUT_VALUE  = 32'h0000_0000;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

endpackage

`default_nettype wire

@@ hdl/lkvc_req_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_req_if
// Request channel: one get or put item with key and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_req_if;
	logic                              valid;
	logic                              ready;
	logic                              command;
	logic signed [lkvc_pkg::KEY_W-1:0] key;
	logic signed [lkvc_pkg::VAL_W-1:0] value;

	modport source (output valid, output command, output key, output value, input ready);
	modport sink   (input valid, input command, input key, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/lkvc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_rsp_if
// Response channel: hit flag and read value of one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic signed [lkvc_pkg::VAL_W-1:0] read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink   (input valid, input hit, input read_value, output ready);
endinterface

`default_nettype wire

@@ hdl/lkvc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_cfg_if
// Configuration write channel for the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lkvc_pkg::CAP_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/lru_key_value_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// All entries (valid mark, recency rank, key, value) live in one memory with a
// registered read port and one write port. Each item makes a search pass over
// the memory (find the key, the first free entry and the oldest entry), then,
// unless it is a get that misses, a read-modify-write pass that updates ranks
// and stores the pair. Both passes sweep every entry through the single memory
// read port, one entry per cycle. After reset the block clears the memory, one
// entry at a time, before it accepts the first item; capacity writes are taken
// at any time. The result goes into an output register, so a new item is
// accepted while an earlier result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	lkvc_req_if.sink    req,
	lkvc_rsp_if.source  rsp,
	lkvc_cfg_if.sink    cfg
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES + 1);
	localparam int MW = (OW > lkvc_pkg::CAP_W) ? OW : lkvc_pkg::CAP_W;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	typedef struct packed {
		logic                       valid;
		logic [IW-1:0]              rank;
		logic [lkvc_pkg::KEY_W-1:0] key;
		logic [lkvc_pkg::VAL_W-1:0] value;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	state_t state_q;

	// memory
	entry_t mem [ENTRIES];
	entry_t rdata_s1;
	entry_t wdata;
	logic   mem_we;
	logic [IW-1:0] waddr;

	// address sweep
	logic [IW-1:0] ptr_q;
	logic          iss_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	// item and search results
	logic                       cmd_q;
	logic [lkvc_pkg::KEY_W-1:0] key_q;
	logic [lkvc_pkg::VAL_W-1:0] val_q;
	logic                       hit_q;
	logic [IW-1:0]              hidx_q;
	logic [IW-1:0]              hrank_q;
	logic [lkvc_pkg::VAL_W-1:0] hval_q;
	logic                       free_found_q;
	logic [IW-1:0]              fidx_q;
	logic                       old_found_q;
	logic [IW-1:0]              oidx_q;
	logic [IW-1:0]              orank_q;
	logic                       evict_q;
	logic [IW-1:0]              sidx_q;

	logic [OW-1:0]              occ_q;
	logic [lkvc_pkg::CAP_W-1:0] cap_q;

	logic                       res_hit_q;
	logic [lkvc_pkg::VAL_W-1:0] res_val_q;
	logic                       rsp_valid_q;
	logic                       rsp_hit_q;
	logic [lkvc_pkg::VAL_W-1:0] rsp_val_q;

	logic [MW-1:0] cap_ext;
	logic [MW-1:0] eff_cap;
	logic          evict_now;
	logic [IW-1:0] slot_now;
	logic          is_match;
	logic          last_s1;
	logic          rsp_load;

	assign req.ready      = (state_q == ST_IDLE);
	assign cfg.ready      = 1'b1;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.read_value = rsp_val_q;

	// load the output register once it is free or being taken
	assign rsp_load = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);

	// effective capacity: zero acts as one, saturate at the entry count
	always_comb begin
		cap_ext = MW'(cap_q);
		if (cap_ext == '0) begin
			eff_cap = MW'(1);
		end else if (cap_ext > MW'(ENTRIES)) begin
			eff_cap = MW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	always_comb begin
		evict_now = (cmd_q == lkvc_pkg::CMD_PUT) && !hit_q && (MW'(occ_q) >= eff_cap);
		if (evict_now && !(free_found_q && (fidx_q < oidx_q))) begin
			slot_now = oidx_q;
		end else begin
			slot_now = fidx_q;
		end
	end

	assign is_match = rdata_s1.valid && (rdata_s1.key == key_q);
	assign last_s1  = (idx_s1 == LAST);

	// write-back word of the clear and update passes
	always_comb begin
		wdata = rdata_s1;
		if (state_q == ST_CLEAR) begin
			wdata = '0;
		end else if (hit_q) begin
			if (idx_s1 == hidx_q) begin
				wdata.rank = '0;
				if (cmd_q == lkvc_pkg::CMD_PUT) begin
					wdata.value = val_q;
				end
			end else if (rdata_s1.valid && (rdata_s1.rank < hrank_q)) begin
				wdata.rank = rdata_s1.rank + 1'b1;
			end
		end else begin
			if (idx_s1 == sidx_q) begin
				wdata.valid = 1'b1;
				wdata.rank  = '0;
				wdata.key   = key_q;
				wdata.value = val_q;
			end else if (evict_q && (idx_s1 == oidx_q)) begin
				wdata.valid = 1'b0;
				wdata.rank  = '0;
			end else if (rdata_s1.valid) begin
				wdata.rank = rdata_s1.rank + 1'b1;
			end
		end
	end

	assign mem_we = (state_q == ST_CLEAR) || ((state_q == ST_UPDATE) && vld_s1);
	assign waddr  = (state_q == ST_CLEAR) ? ptr_q : idx_s1;

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[ptr_q];
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ptr_q        <= '0;
			iss_q        <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			cmd_q        <= lkvc_pkg::CMD_GET;
			key_q        <= '0;
			val_q        <= '0;
			hit_q        <= 1'b0;
			hidx_q       <= '0;
			hrank_q      <= '0;
			hval_q       <= '0;
			free_found_q <= 1'b0;
			fidx_q       <= '0;
			old_found_q  <= 1'b0;
			oidx_q       <= '0;
			orank_q      <= '0;
			evict_q      <= 1'b0;
			sidx_q       <= '0;
			occ_q        <= '0;
			cap_q        <= lkvc_pkg::CAP_RESET;
			res_hit_q    <= 1'b0;
			res_val_q    <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_hit_q    <= 1'b0;
			rsp_val_q    <= '0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (rsp.ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end

			// read sweep: issue one address a cycle, wrap to zero after the last
			if (iss_q) begin
				vld_s1 <= 1'b1;
				idx_s1 <= ptr_q;
				if (ptr_q == LAST) begin
					ptr_q <= '0;
					iss_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end else begin
				vld_s1 <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (ptr_q == LAST) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q        <= req.command;
						key_q        <= req.key;
						val_q        <= req.value;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						old_found_q  <= 1'b0;
						ptr_q        <= '0;
						iss_q        <= 1'b1;
						state_q      <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (vld_s1) begin
						if (is_match && !hit_q) begin
							hit_q   <= 1'b1;
							hidx_q  <= idx_s1;
							hrank_q <= rdata_s1.rank;
							hval_q  <= rdata_s1.value;
						end
						if (!rdata_s1.valid && !free_found_q) begin
							free_found_q <= 1'b1;
							fidx_q       <= idx_s1;
						end
						if (rdata_s1.valid && (!old_found_q || (rdata_s1.rank > orank_q))) begin
							old_found_q <= 1'b1;
							oidx_q      <= idx_s1;
							orank_q     <= rdata_s1.rank;
						end
						if (last_s1) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					res_hit_q <= hit_q;
					if (cmd_q == lkvc_pkg::CMD_PUT) begin
						res_val_q <= lkvc_pkg::PUT_VALUE;
					end else if (hit_q) begin
						res_val_q <= hval_q;
					end else begin
						res_val_q <= lkvc_pkg::MISS_VALUE;
					end
					evict_q <= evict_now;
					sidx_q  <= slot_now;
					if ((cmd_q == lkvc_pkg::CMD_PUT) && !hit_q && !evict_now) begin
						occ_q <= occ_q + 1'b1;
					end
					if ((cmd_q == lkvc_pkg::CMD_GET) && !hit_q) begin
						state_q <= ST_FINISH;
					end else begin
						ptr_q   <= '0;
						iss_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (vld_s1 && last_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// hold the result until the output register is free
					if (rsp_load) begin
						rsp_valid_q <= 1'b1;
						rsp_hit_q   <= res_hit_q;
						rsp_val_q   <= res_val_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(ENTRIES))
		else $error("occupancy above entry count");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && vld_s1 && iss_q) |-> (idx_s1 != ptr_q))
		else $error("update writes the entry being read");

	a_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && cmd_q == lkvc_pkg::CMD_PUT && !hit_q && !evict_now)
		|-> free_found_q)
		else $error("insert without a free entry");

	a_evict_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && evict_now) |-> old_found_q)
		else $error("eviction without a valid entry");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> rsp_valid_q)
		else $error("result not loaded at finish");
`endif

endmodule

`default_nettype wire
